// ----- rtl/s1bh_pkg.sv -----
// Package for the SHA-1 byte stream hasher: payload and command types,
// SHA-1 constants and the one-hot state codes of the controller.
// No dependencies.
package s1bh_pkg;

	localparam int LENGTH_BITS_DEF = 32;
	localparam int DIGEST_WORDS    = 5;
	localparam int ROUNDS          = 80;

	localparam logic [2:0]  LAST_WORD_IDX = 3'(DIGEST_WORDS - 1);
	localparam logic [6:0]  LAST_ROUND    = 7'(ROUNDS - 1);
	localparam logic [5:0]  LEN_START_POS = 6'd56;
	localparam logic [5:0]  BLOCK_END_POS = 6'd63;
	localparam logic [7:0]  PAD_MARK      = 8'h80;

	localparam logic [31:0] INIT_CHAIN [DIGEST_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic [31:0] K_0 = 32'h5a827999;
	localparam logic [31:0] K_1 = 32'h6ed9eba1;
	localparam logic [31:0] K_2 = 32'h8f1bbcdc;
	localparam logic [31:0] K_3 = 32'hca62c1d6;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic absorb;     // input transfer this cycle
		logic load_work;  // copy chain words into working registers
		logic do_round;   // one compression round
		logic add_chain;  // fold working registers into chain words
		logic pad_byte;   // insert one padding byte
		logic out_next;   // digest word transferred
		logic restart;    // reinitialise for the next message
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic block_full;   // next byte placed completes the block
		logic round_last;   // current round is the eightieth
		logic length_byte;  // next padding byte is a length byte
		logic last_word;    // digest word on show is the fifth
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ROUND = 5'b00010,
		ST_ADD   = 5'b00100,
		ST_PAD   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

endpackage

// ----- rtl/s1bh_stream_if.sv -----
// Valid/ready stream channel with a typed payload.
// No dependencies.
interface s1bh_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/sha1_byte_stream_hasher.sv -----
// SHA-1 hasher over a byte stream. A byte that does not complete a block
// is absorbed in the idle state; the 64th byte of a block starts a compression:
// 80 rounds at one round a cycle in the round loop, then the chain add.
// End of message: one padding byte a cycle, one or two compressions, then
// five digest transfers. Reset (async, active low) loads the SHA-1 initial
// chain and clears counters; the block window is not reset.
module sha1_byte_stream_hasher
	import s1bh_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input logic             clk,
	input logic             arst_n,
	s1bh_stream_if.sink     in_ch,
	s1bh_stream_if.source   out_ch
);

	cmd_t      cmd;
	status_t   status;
	in_item_t  in_item;
	out_item_t out_item;

	assign in_item        = in_ch.payload;
	assign out_ch.payload = out_item;

	s1bh_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_item   (in_item),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	s1bh_datapath #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_item  (in_item),
		.status   (status),
		.out_item (out_item)
	);

	// Input and output never open together
	a_in_out_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input ready while digest on show");

	// Last digest transfer returns the block to taking input
	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.payload.last_word) |=> in_ch.ready)
		else $error("no return to input after last digest word");

	// Round loop stops after the eightieth round
	a_round_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.do_round && status.round_last) |=> (!cmd.do_round && cmd.add_chain))
		else $error("round loop overran");

endmodule

// ----- rtl/s1bh_datapath.sv -----
// SHA-1 datapath: 512-bit block window, message schedule, round logic,
// chaining words, byte and length counters, padding and digest selection.
// Depends on s1bh_pkg.
module s1bh_datapath
	import s1bh_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  in_item_t  in_item,
	output status_t   status,
	output out_item_t out_item
);

	logic [511:0]           window_q;
	logic [31:0]            chain_q [DIGEST_WORDS];
	logic [31:0]            a_q, b_q, c_q, d_q, e_q;
	logic [5:0]             byte_cnt_q;
	logic [LENGTH_BITS-1:0] msg_cnt_q;
	logic [6:0]             round_q;
	logic [2:0]             out_idx_q;
	logic                   mark_sent_q;
	logic                   len_phase_q;

	logic        put_en;
	logic [7:0]  put_byte;
	logic        is_len;
	logic [63:0] len_bits;
	logic [7:0]  len_byte;
	logic [31:0] f_val, k_val, t_val, w_new;

	// Padding byte selection
	assign is_len   = mark_sent_q && (len_phase_q || byte_cnt_q == LEN_START_POS);
	assign len_bits = 64'(msg_cnt_q) << 3;
	assign len_byte = len_bits[{3'd7 - byte_cnt_q[2:0], 3'b000} +: 8];

	always_comb begin
		put_en   = 1'b0;
		put_byte = in_item.data_byte;
		if (cmd.absorb && in_item.byte_valid) begin
			put_en = 1'b1;
		end else if (cmd.pad_byte) begin
			put_en = 1'b1;
			if (!mark_sent_q)
				put_byte = PAD_MARK;
			else if (is_len)
				put_byte = len_byte;
			else
				put_byte = 8'h00;
		end
	end

	// Round function and constant by round group
	always_comb begin
		if (round_q < 7'd20) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K_0;
		end else if (round_q < 7'd40) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_1;
		end else if (round_q < 7'd60) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K_2;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_3;
		end
	end

	assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + window_q[511:480] + k_val;

	// Schedule: w[t+16] from taps t+13, t+8, t+2, t of the window
	logic [31:0] w_mix;
	assign w_mix = window_q[95:64] ^ window_q[255:224] ^ window_q[447:416]
		^ window_q[511:480];
	assign w_new = {w_mix[30:0], w_mix[31]};

	// Block window: bytes shift in, schedule words shift through
	always_ff @(posedge clk) begin
		if (put_en)
			window_q <= {window_q[503:0], put_byte};
		else if (cmd.do_round)
			window_q <= {window_q[479:0], w_new};
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load_work) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (cmd.do_round) begin
			a_q <= t_val;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	// Chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGEST_WORDS; i++)
				chain_q[i] <= INIT_CHAIN[i];
		end else if (cmd.restart) begin
			for (int i = 0; i < DIGEST_WORDS; i++)
				chain_q[i] <= INIT_CHAIN[i];
		end else if (cmd.add_chain) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
			chain_q[4] <= chain_q[4] + e_q;
		end
	end

	// Counters and padding flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q  <= '0;
			msg_cnt_q   <= '0;
			round_q     <= '0;
			out_idx_q   <= '0;
			mark_sent_q <= 1'b0;
			len_phase_q <= 1'b0;
		end else if (cmd.restart) begin
			byte_cnt_q  <= '0;
			msg_cnt_q   <= '0;
			round_q     <= '0;
			out_idx_q   <= '0;
			mark_sent_q <= 1'b0;
			len_phase_q <= 1'b0;
		end else begin
			if (put_en)
				byte_cnt_q <= byte_cnt_q + 6'd1;
			if (cmd.absorb && in_item.byte_valid)
				msg_cnt_q <= msg_cnt_q + 1'b1;
			if (cmd.pad_byte) begin
				mark_sent_q <= 1'b1;
				if (is_len)
					len_phase_q <= 1'b1;
			end
			if (cmd.load_work)
				round_q <= '0;
			else if (cmd.do_round)
				round_q <= round_q + 7'd1;
			if (cmd.out_next)
				out_idx_q <= out_idx_q + 3'd1;
		end
	end

	// Status back to the controller
	assign status.block_full  = (byte_cnt_q == BLOCK_END_POS);
	assign status.round_last  = (round_q == LAST_ROUND);
	assign status.length_byte = is_len;
	assign status.last_word   = (out_idx_q == LAST_WORD_IDX);

	// Digest word on show
	always_comb begin
		case (out_idx_q)
			3'd0:    out_item.digest_word = chain_q[0];
			3'd1:    out_item.digest_word = chain_q[1];
			3'd2:    out_item.digest_word = chain_q[2];
			3'd3:    out_item.digest_word = chain_q[3];
			default: out_item.digest_word = chain_q[4];
		endcase
	end
	assign out_item.word_index = out_idx_q;
	assign out_item.last_word  = (out_idx_q == LAST_WORD_IDX);

endmodule

// ----- rtl/s1bh_controller.sv -----
// Controller state machine: input transfers, compression sequencing,
// padding and digest output.
// Depends on s1bh_pkg.
module s1bh_controller
	import s1bh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  in_item_t in_item,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  status_t  status,
	output cmd_t     cmd
);

	state_t state_q, state_d;
	logic   closing_q, closing_d;  // message closed, padding owed
	logic   done_q, done_d;        // compression in flight is the final one

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		closing_d = closing_q;
		done_d    = done_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.absorb = 1'b1;
					closing_d  = in_item.end_of_message;
					done_d     = 1'b0;
					if (in_item.byte_valid && status.block_full) begin
						cmd.load_work = 1'b1;
						state_d       = ST_ROUND;
					end else if (in_item.end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_ROUND: begin
				cmd.do_round = 1'b1;
				if (status.round_last)
					state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add_chain = 1'b1;
				if (done_q)
					state_d = ST_OUT;
				else if (closing_q)
					state_d = ST_PAD;
				else
					state_d = ST_IDLE;
			end
			ST_PAD: begin
				cmd.pad_byte = 1'b1;
				if (status.block_full) begin
					cmd.load_work = 1'b1;
					done_d        = status.length_byte;
					state_d       = ST_ROUND;
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					cmd.out_next = 1'b1;
					if (status.last_word) begin
						cmd.restart = 1'b1;
						closing_d   = 1'b0;
						done_d      = 1'b0;
						state_d     = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			closing_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			closing_q <= closing_d;
			done_q    <= done_d;
		end
	end

endmodule

// ----- verif/s1bh_digest_sb_pkg.sv -----
`timescale 1ns / 100ps
// Digest scoreboard for the SHA-1 byte stream hasher: a software SHA-1 that predicts
// the five digest words of each closed message and checks them in order.
// Depends on s1bh_pkg for the payload types and the SHA-1 constants.
package s1bh_digest_sb_pkg;
	import s1bh_pkg::*;

	class digest_scoreboard;
		int unsigned len_bits;
		logic [63:0] count_mask;
		logic [31:0] chain [DIGEST_WORDS];
		logic [31:0] block [16];
		logic [5:0]  fill;
		logic [63:0] byte_total;
		out_item_t   digest_q [$];
		int unsigned errors;

		function new(int unsigned length_bits);
			len_bits   = length_bits;
			count_mask = (64'd1 << length_bits) - 64'd1;
			errors     = 0;
			foreach (block[i]) block[i] = '0;
			restart();
		endfunction

		function void restart();
			foreach (chain[i]) chain[i] = INIT_CHAIN[i];
			fill       = '0;
			byte_total = '0;
		endfunction

		function logic [31:0] rotl(logic [31:0] v, int unsigned s);
			return (v << s) | (v >> (32 - s));
		endfunction

		// 80-round compression of the current block into the chain
		function void compress();
			logic [31:0] w [80];
			logic [31:0] a, b, c, d, e, f, k, t;
			for (int i = 0; i < 16; i++) w[i] = block[i];
			for (int i = 16; i < 80; i++)
				w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
			a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
			for (int i = 0; i < 80; i++) begin
				if (i < 20) begin
					f = (b & c) | (~b & d);
					k = K_0;
				end else if (i < 40) begin
					f = b ^ c ^ d;
					k = K_1;
				end else if (i < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = K_2;
				end else begin
					f = b ^ c ^ d;
					k = K_3;
				end
				t = rotl(a, 5) + f + e + w[i] + k;
				e = d;
				d = c;
				c = rotl(b, 30);
				b = a;
				a = t;
			end
			chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
		endfunction

		// big-endian byte placement; the 64th byte triggers a compression
		function void absorb(logic [7:0] data);
			logic [31:0] lane;
			lane = {24'd0, data} << ((3 - fill[1:0]) * 8);
			if (fill[1:0] == 2'd0) block[fill[5:2]] = lane;
			else                   block[fill[5:2]] |= lane;
			if (fill == BLOCK_END_POS) compress();
			fill = fill + 6'd1;
		endfunction

		// called on each input transfer
		function void note_input(in_item_t it);
			logic [63:0] bit_len;
			if (it.byte_valid) begin
				absorb(it.data_byte);
				byte_total = (byte_total + 64'd1) & count_mask;
			end
			if (!it.end_of_message) return;
			bit_len = (byte_total & count_mask) << 3;
			absorb(PAD_MARK);
			while (fill != LEN_START_POS) absorb(8'h00);
			for (int i = 7; i >= 0; i--) absorb(bit_len[8*i +: 8]);
			for (int i = 0; i < DIGEST_WORDS; i++)
				digest_q.push_back('{digest_word: chain[i], word_index: 3'(i),
					last_word: (3'(i) == LAST_WORD_IDX)});
			restart();
		endfunction

		// called on each output transfer
		function void check_result(out_item_t got);
			out_item_t want;
			if (digest_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected digest transfer: word %h index %0d last %0b",
					$time, got.digest_word, got.word_index, got.last_word);
				return;
			end
			want = digest_q.pop_front();
			if (got.digest_word !== want.digest_word) begin
				errors++;
				$display("%0t: digest_word mismatch: expected %h actual %h",
					$time, want.digest_word, got.digest_word);
			end
			if (got.word_index !== want.word_index) begin
				errors++;
				$display("%0t: word_index mismatch: expected %0d actual %0d",
					$time, want.word_index, got.word_index);
			end
			if (got.last_word !== want.last_word) begin
				errors++;
				$display("%0t: last_word mismatch: expected %0b actual %0b",
					$time, want.last_word, got.last_word);
			end
		endfunction

		function int unsigned pending();
			return digest_q.size();
		endfunction
	endclass

endpackage

// ----- verif/sha1_byte_stream_hasher_tb.sv -----
`timescale 1ns / 100ps
// Top-level testbench for sha1_byte_stream_hasher: drives byte messages with random
// gaps and back-pressure, and checks digests against the scoreboard's own SHA-1.
// Depends on s1bh_pkg, s1bh_stream_if and s1bh_digest_sb_pkg.
module sha1_byte_stream_hasher_tb;
	import s1bh_pkg::*;
	import s1bh_digest_sb_pkg::*;

	localparam int          LENGTH_BITS    = LENGTH_BITS_DEF;
	localparam int unsigned RANDOM_ITEMS   = 380;
	localparam int unsigned HOLD_OFF_AT    = 20;
	localparam int unsigned HOLD_OFF_LEN   = 700;
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned DRAIN_CYCLES   = 400;

	logic clk = 1'b0;
	logic arst_n;

	s1bh_stream_if #(.payload_t(in_item_t))  in_ch ();
	s1bh_stream_if #(.payload_t(out_item_t)) out_ch ();

	sha1_byte_stream_hasher #(.LENGTH_BITS(LENGTH_BITS)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	digest_scoreboard sb;
	int unsigned items_sent = 0;
	int unsigned words_seen = 0;
	int unsigned idle_cycles = 0;
	bit          fast_send = 1'b0;
	bit          fast_recv = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// one input transfer, after a random gap unless in a no-idle stretch
	task automatic send_item(input logic [7:0] data, input logic has_byte, input logic close);
		int unsigned gap;
		gap = fast_send ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= in_item_t'{data_byte: data, byte_valid: has_byte,
			end_of_message: close};
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		sb.note_input(in_ch.payload);
		items_sent++;
	endtask

	// random message; closed on its last byte or by a separate byteless end
	task automatic send_message(input int unsigned n_bytes, input bit close_apart,
		input bit noisy);
		for (int unsigned i = 0; i < n_bytes; i++) begin
			if (noisy && $urandom_range(0, 7) == 0)
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(0, 255)), 1'b1,
				!close_apart && (i == n_bytes - 1));
		end
		if (close_apart || n_bytes == 0)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// mostly short messages, with the padding and block boundaries weighted in
	function automatic int unsigned pick_length();
		case ($urandom_range(0, 9))
			6:       return 55 + $urandom_range(0, 2);
			7:       return 63 + $urandom_range(0, 2);
			8:       return $urandom_range(0, 130);
			9:       return 119 + $urandom_range(0, 1) + (($urandom_range(0, 1) == 1) ? 8 : 0);
			default: return $urandom_range(0, 12);
		endcase
	endfunction

	// stimulus and end of run
	initial begin
		int unsigned target;
		sb = new(LENGTH_BITS);
		arst_n        <= 1'b0;
		in_ch.valid   <= 1'b0;
		in_ch.payload <= '0;
		out_ch.ready  <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, byte extremes, "abc", idles, byteless close
		send_item(8'h5a, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'hc3, 1'b0, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		fast_send = 1'b1;
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'ha5, 1'b1, 1'b0);
		send_item(8'h3c, 1'b0, 1'b0);
		send_item(8'hff, 1'b0, 1'b1);
		fast_send = 1'b0;
		send_item(8'h80, 1'b1, 1'b0);
		send_item(8'h01, 1'b1, 1'b0);
		send_item(8'h7f, 1'b1, 1'b0);
		send_item(8'hfe, 1'b1, 1'b1);

		// random messages
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			fast_send = ($urandom_range(0, 3) == 0);
			send_message(pick_length(), $urandom_range(0, 2) == 0, $urandom_range(0, 1) == 1);
		end
		in_ch.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("sha1_byte_stream_hasher_tb: done, clean");
		end else begin
			$display("sha1_byte_stream_hasher_tb: done, errors");
		end
		$finish;
	end

	// digest receiver with random stalls and one long hold-off
	initial begin
		int unsigned hold;
		bit          held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && words_seen == HOLD_OFF_AT) begin
				hold = HOLD_OFF_LEN;
				held = 1'b1;
			end else begin
				hold = fast_recv ? 0 : $urandom_range(0, 14);
			end
			if (hold > 0) begin
				out_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
			sb.check_result(out_ch.payload);
			words_seen++;
			if (out_ch.payload.last_word) fast_recv = ($urandom_range(0, 3) == 0);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("sha1_byte_stream_hasher_tb: done, errors");
				$finish;
			end
		end
	end

endmodule
